FILE: hdl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

  // command codes
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_ADD      = 2'd1;
  localparam logic [1:0] ACT_DISPATCH = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam int SLOT_W = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  task_tag;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic        cooperative;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        run_tag;
    logic [31:0]       tick_count;
    logic              last;
  } res_t;

  // one row of the task table
  typedef struct packed {
    logic [7:0]  tag;
    logic        coop;
    logic [7:0]  runs;
    logic [15:0] delay;
    logic [15:0] period;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic add;
    logic walk;
    logic done;
  } ctl_t;

endpackage

FILE: hdl/tts_ctrl.sv
`timescale 1ns / 1ps

module tts_ctrl #(
  parameter int TASK_SLOTS = 8,
  parameter int IDX_W      = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       action,
  output logic             busy,
  output tts_pkg::ctl_t    ctl,
  output logic [IDX_W-1:0] ptr
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] ptr_next;
  logic             ptr_last;

  assign ptr_last = (ptr == IDX_W'(TASK_SLOTS - 1));

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ptr_next = '0;
          unique case (action) inside
            tts_pkg::ACT_ADD: state_next = S_ADD;
            tts_pkg::ACT_TICK, tts_pkg::ACT_DISPATCH: state_next = S_WALK;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ADD: state_next = S_IDLE;
      S_WALK: begin
        if (ptr_last) begin
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign ctl.accept = (state == S_IDLE) && start;
  assign ctl.add    = (state == S_ADD);
  assign ctl.walk   = (state == S_WALK);
  assign ctl.done   = (state == S_DONE);

endmodule

FILE: hdl/tts_dp.sv
`timescale 1ns / 1ps

module tts_dp #(
  parameter int TASK_SLOTS = 8,
  parameter int IDX_W      = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  tts_pkg::ctl_t    ctl,
  input  logic [IDX_W-1:0] ptr,
  input  tts_pkg::cmd_t    command,
  output tts_pkg::res_t    result,
  output logic             result_valid
);

  tts_pkg::entry_t mem [TASK_SLOTS];
  tts_pkg::entry_t rdata;
  tts_pkg::entry_t wdata;
  tts_pkg::entry_t upd;
  tts_pkg::cmd_t   op;
  tts_pkg::res_t   res_next;

  logic [TASK_SLOTS-1:0] valid;
  logic [31:0]           tick_counter;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  we;
  logic                  vld;
  logic                  emit;
  logic                  release_slot;

  // latched command and tick counter
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
    end else if (ctl.accept && command.action == tts_pkg::ACT_TICK) begin
      tick_counter <= tick_counter + 32'd1;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // prefetch the next slot while the current one is updated
  always_comb begin
    rd_addr = '0;
    if (ctl.walk && ptr != IDX_W'(TASK_SLOTS - 1)) begin
      rd_addr = ptr + IDX_W'(1);
    end
  end

  assign vld = valid[ptr];

  // per-slot update for tick or dispatch
  always_comb begin
    upd          = rdata;
    emit         = 1'b0;
    release_slot = 1'b0;
    if (op.action == tts_pkg::ACT_TICK) begin
      if (rdata.delay == '0) begin
        if (rdata.coop) begin
          if (rdata.runs != 8'hFF) begin
            upd.runs = rdata.runs + 8'd1;
          end
        end else begin
          emit = 1'b1;
          if (rdata.period == '0) begin
            release_slot = 1'b1;
          end
        end
        if (rdata.period != '0) begin
          upd.delay = rdata.period;
        end
      end else begin
        upd.delay = rdata.delay - 16'd1;
      end
    end else begin
      if (rdata.coop && rdata.runs != '0) begin
        upd.runs = rdata.runs - 8'd1;
        emit     = 1'b1;
        if (rdata.period == '0) begin
          release_slot = 1'b1;
        end
      end
    end
  end

  // single write port: add or walk write-back
  always_comb begin
    we      = 1'b0;
    wr_addr = ptr;
    wdata   = upd;
    if (ctl.add) begin
      we           = free_found;
      wr_addr      = free_idx;
      wdata.tag    = op.task_tag;
      wdata.coop   = op.cooperative;
      wdata.runs   = '0;
      wdata.delay  = op.start_delay;
      wdata.period = op.repeat_period;
    end else if (ctl.walk) begin
      we = vld;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // invalid rows read as freed
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.add && free_found) begin
      valid[free_idx] <= 1'b1;
    end else if (ctl.walk && vld && release_slot) begin
      valid[ptr] <= 1'b0;
    end
  end

  // result register
  always_comb begin
    res_next.kind       = tts_pkg::KIND_DONE;
    res_next.slot       = '0;
    res_next.run_tag    = '0;
    res_next.tick_count = tick_counter;
    res_next.last       = 1'b1;
    if (ctl.add) begin
      res_next.kind = tts_pkg::KIND_ADD;
      res_next.slot = free_found ? tts_pkg::SLOT_W'(free_idx)
                                 : tts_pkg::SLOT_W'(TASK_SLOTS);
    end else if (ctl.walk) begin
      res_next.kind    = tts_pkg::KIND_RUN;
      res_next.slot    = tts_pkg::SLOT_W'(ptr);
      res_next.run_tag = rdata.tag;
      res_next.last    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.add || ctl.done || (ctl.walk && vld && emit);
    end
  end

endmodule

FILE: hdl/tick_task_scheduler.sv
`timescale 1ns / 1ps

// tick-driven task scheduler with a table of TASK_SLOTS slots. a command is
// taken when start is high and busy is low. an add gives one answer beat; a
// tick or a dispatch walks the table one slot per cycle through the single
// read port of the table memory and gives its run beats in slot order,
// followed by a done beat with last set; an unused code gives a done beat.
// every beat shows on result for exactly one cycle with result_valid high and
// cannot be held off, so the receiver must take it there and then. busy drops
// in the cycle the last beat is shown.
module tick_task_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tts_pkg::cmd_t command,
  output logic          busy,
  output tts_pkg::res_t result,
  output logic          result_valid
);

  // slot index width, at least one bit
  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  tts_pkg::ctl_t    ctl;
  logic [IDX_W-1:0] ptr;

  // sequencer: idle, add, slot walk, done beat
  tts_ctrl #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (command.action),
    .busy   (busy),
    .ctl    (ctl),
    .ptr    (ptr)
  );

  // task table memory, valid bits, tick counter and result register
  tts_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .ptr          (ptr),
    .command      (command),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef SYNTHESIS
  // a command ends exactly with its last beat
  a_end_with_last : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && result.last)
    else $error("busy dropped without a last beat");

  // a last beat closes a command that was in progress
  a_last_closes : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy && $past(busy))
    else $error("last beat outside a command");

  // run beats come only from the walk and are never last
  a_run_in_walk : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == tts_pkg::KIND_RUN |-> !result.last && busy)
    else $error("run beat out of place");
`endif

endmodule
